@@ design/rtt_estimator_rto_unit_assert.svh @@
// ----------------------------------------------------------------------------
// RTT estimator assertion macros
// Shared forms for the concurrent assertions of the RTT estimator checker.
// ----------------------------------------------------------------------------
`ifndef RTT_ESTIMATOR_RTO_UNIT_ASSERT_SVH
`define RTT_ESTIMATOR_RTO_UNIT_ASSERT_SVH

// Same-cycle implication, switched off while reset is high.
`define RTTE_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rtte: same-cycle property failed");

// Next-cycle implication, switched off while reset is high.
`define RTTE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rtte: next-cycle property failed");

// Next-cycle implication that is also checked through reset.
`define RTTE_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("rtte: reset property failed");

`endif

@@ design/rtte_pkg.sv @@
// ----------------------------------------------------------------------------
// RTT estimator package
// Request kinds, register indexes and fixed constants of the RTT estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package rtte_pkg;

   typedef enum logic [1:0] {
      REQ_SAMPLE = 2'd0,
      REQ_LOOKUP = 2'd1,
      REQ_NORMAL = 2'd2,
      REQ_UNUSED = 2'd3
   } req_kind_type;

   localparam int CSR_ADDR_WIDTH = 3;

   typedef enum logic [CSR_ADDR_WIDTH-1:0] {
      CSR_VAR_GAIN     = 3'd0,
      CSR_RTO_FLOOR    = 3'd1,
      CSR_RTO_CEILING  = 3'd2,
      CSR_SAMPLE_FLOOR = 3'd3,
      CSR_INIT_SRTT    = 3'd4,
      CSR_INIT_DEV     = 3'd5
   } csr_index_type;

   localparam int GAIN_WIDTH   = 4;
   localparam int SRTT_SHIFT   = 3;   // smoothed RTT moves by one eighth
   localparam int DEV_SHIFT    = 2;   // deviation moves by one quarter
   localparam int NORMAL_SHIFT = 2;   // normal queries use four times the gain

   localparam logic [GAIN_WIDTH-1:0] VAR_GAIN_RESET = 4'd4;
   localparam longint RTO_FLOOR_RESET    = 200000;
   localparam longint RTO_CEILING_RESET  = 60000000;
   localparam longint SAMPLE_FLOOR_RESET = 500;
   localparam longint INIT_SRTT_RESET    = 100000;
   localparam longint INIT_DEV_RESET     = 50000;

   // Decoded request of the item in the input register.
   typedef struct packed {
      logic         valid;
      req_kind_type kind;
   } req_ctrl_type;

endpackage

`default_nettype wire

@@ design/rtte_csr.sv @@
// ----------------------------------------------------------------------------
// RTT estimator configuration registers
// Holds the gain, clamp limits, sample floor and initial estimator values.
// ----------------------------------------------------------------------------
`default_nettype none

module rtte_csr
   import rtte_pkg::*;
#(
   parameter int TIME_BITS = 26
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_wen,
   input  wire logic [CSR_ADDR_WIDTH-1:0] csr_addr,
   input  wire logic [TIME_BITS-1:0]      csr_wdata,
   output logic      [GAIN_WIDTH-1:0]     var_gain,
   output logic      [TIME_BITS-1:0]      rto_floor,
   output logic      [TIME_BITS-1:0]      rto_ceiling,
   output logic      [TIME_BITS-1:0]      sample_floor,
   output logic      [TIME_BITS-1:0]      init_srtt,
   output logic      [TIME_BITS-1:0]      init_dev
);

   logic [GAIN_WIDTH-1:0] var_gain_ff;
   logic [TIME_BITS-1:0]  rto_floor_ff;
   logic [TIME_BITS-1:0]  rto_ceiling_ff;
   logic [TIME_BITS-1:0]  sample_floor_ff;
   logic [TIME_BITS-1:0]  init_srtt_ff;
   logic [TIME_BITS-1:0]  init_dev_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         var_gain_ff     <= VAR_GAIN_RESET;
         rto_floor_ff    <= TIME_BITS'(RTO_FLOOR_RESET);
         rto_ceiling_ff  <= TIME_BITS'(RTO_CEILING_RESET);
         sample_floor_ff <= TIME_BITS'(SAMPLE_FLOOR_RESET);
         init_srtt_ff    <= TIME_BITS'(INIT_SRTT_RESET);
         init_dev_ff     <= TIME_BITS'(INIT_DEV_RESET);
      end else if (csr_wen) begin
         case (csr_index_type'(csr_addr))
            CSR_VAR_GAIN:     var_gain_ff     <= csr_wdata[GAIN_WIDTH-1:0];
            CSR_RTO_FLOOR:    rto_floor_ff    <= csr_wdata;
            CSR_RTO_CEILING:  rto_ceiling_ff  <= csr_wdata;
            CSR_SAMPLE_FLOOR: sample_floor_ff <= csr_wdata;
            CSR_INIT_SRTT:    init_srtt_ff    <= csr_wdata;
            CSR_INIT_DEV:     init_dev_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign var_gain     = var_gain_ff;
   assign rto_floor    = rto_floor_ff;
   assign rto_ceiling  = rto_ceiling_ff;
   assign sample_floor = sample_floor_ff;
   assign init_srtt    = init_srtt_ff;
   assign init_dev     = init_dev_ff;

endmodule

`default_nettype wire

@@ design/rtte_estimator.sv @@
// ----------------------------------------------------------------------------
// RTT estimator datapath
// Smoothed RTT and mean deviation registers with the sample update and the
// clamped RTO computed in one pass for the item in the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module rtte_estimator
   import rtte_pkg::*;
#(
   parameter int TIME_BITS = 26,
   parameter int FRAC_BITS = 3
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire req_ctrl_type          ctrl,       // valid means the item retires now
   input  wire logic [TIME_BITS-1:0]  sample,
   input  wire logic [GAIN_WIDTH-1:0] var_gain,
   input  wire logic [TIME_BITS-1:0]  rto_floor,
   input  wire logic [TIME_BITS-1:0]  rto_ceiling,
   input  wire logic [TIME_BITS-1:0]  sample_floor,
   input  wire logic [TIME_BITS-1:0]  init_srtt,
   input  wire logic [TIME_BITS-1:0]  init_dev,
   output logic      [TIME_BITS-1:0]  rto
);

   localparam int EST_W  = TIME_BITS + FRAC_BITS;
   localparam int PROD_W = EST_W + GAIN_WIDTH;
   localparam int SUM_W  = PROD_W + NORMAL_SHIFT + 1;
   localparam int RAW_W  = SUM_W - FRAC_BITS;

   logic [EST_W-1:0]  srtt_ff, srtt_in;
   logic [EST_W-1:0]  dev_ff, dev_in;
   logic              init_ff, init_in;

   logic [EST_W-1:0]  target;
   logic              srtt_up, dev_up;
   logic [EST_W-1:0]  err, dev_diff;
   logic [EST_W-1:0]  srtt_upd, dev_upd;
   logic              load;
   logic [EST_W-1:0]  srtt_use, dev_use;
   logic [PROD_W-1:0] prod;
   logic [SUM_W-1:0]  term, sum;
   logic [RAW_W-1:0]  rto_raw;

   // Sample update: each estimator steps toward its target, truncated toward zero.
   assign target   = {sample, {FRAC_BITS{1'b0}}};
   assign srtt_up  = target >= srtt_ff;
   assign err      = srtt_up ? target - srtt_ff : srtt_ff - target;
   assign srtt_upd = srtt_up ? srtt_ff + (err >> SRTT_SHIFT)
                             : srtt_ff - (err >> SRTT_SHIFT);
   assign dev_up   = err >= dev_ff;
   assign dev_diff = dev_up ? err - dev_ff : dev_ff - err;
   assign dev_upd  = dev_up ? dev_ff + (dev_diff >> DEV_SHIFT)
                            : dev_ff - (dev_diff >> DEV_SHIFT);

   // The first lookup sees the initial values straight away.
   assign load     = (ctrl.kind == REQ_LOOKUP) && !init_ff;
   assign srtt_use = load ? {init_srtt, {FRAC_BITS{1'b0}}} : srtt_ff;
   assign dev_use  = load ? {init_dev, {FRAC_BITS{1'b0}}} : dev_ff;

   assign prod    = PROD_W'(dev_use) * PROD_W'(var_gain);
   assign term    = (ctrl.kind == REQ_NORMAL) ? (SUM_W'(prod) << NORMAL_SHIFT)
                                              : SUM_W'(prod);
   assign sum     = SUM_W'(srtt_use) + term;
   assign rto_raw = sum[SUM_W-1:FRAC_BITS];

   always_comb begin
      if (rto_raw < RAW_W'(rto_floor)) begin
         rto = rto_floor;
      end else if (rto_raw > RAW_W'(rto_ceiling)) begin
         rto = rto_ceiling;
      end else begin
         rto = rto_raw[TIME_BITS-1:0];
      end
   end

   always_comb begin
      srtt_in = srtt_ff;
      dev_in  = dev_ff;
      init_in = init_ff;
      if (ctrl.valid) begin
         case (ctrl.kind)
            REQ_SAMPLE: begin
               if (sample >= sample_floor) begin
                  srtt_in = srtt_upd;
                  dev_in  = dev_upd;
               end
            end
            REQ_LOOKUP: begin
               if (load) begin
                  srtt_in = srtt_use;
                  dev_in  = dev_use;
                  init_in = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         srtt_ff <= '0;
         dev_ff  <= '0;
         init_ff <= 1'b0;
      end else begin
         srtt_ff <= srtt_in;
         dev_ff  <= dev_in;
         init_ff <= init_in;
      end
   end

endmodule

`default_nettype wire

@@ design/rtt_estimator_rto_unit.sv @@
// ----------------------------------------------------------------------------
// RTT estimator with retransmission timeout
// Jacobson round-trip estimator: samples update the smoothed RTT and mean
// deviation, queries return the clamped RTO.
//
//   Channel  Dir  Handshake                Contents
//   req      in   req_tvalid/req_tready    tuser: kind; tdata: sample in us
//   rsp      out  rsp_tvalid/rsp_tready    tdata: clamped RTO in us
//   csr      in   csr_wen                  csr_addr selects, csr_wdata value
//
// One item per cycle while no stalled result holds a query. A query passes
// through the input register, then through the estimator's multiply-add-clamp
// pass into the result register, from which its RTO is presented.
// Reset is synchronous and clears both registers' valid flags and the
// estimators, and reloads the configuration defaults. A stalled result holds
// the query behind it, but sample items still retire and update the estimators.
// ----------------------------------------------------------------------------
`default_nettype none

module rtt_estimator_rto_unit
   import rtte_pkg::*;
#(
   parameter int TIME_BITS = 26,
   parameter int FRAC_BITS = 3
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [((TIME_BITS+7)/8)*8-1:0] req_tdata,  // [TIME_BITS-1:0] sample_us
   input  wire logic [1:0]                    req_tuser,  // [1:0] req_type
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic      [((TIME_BITS+7)/8)*8-1:0] rsp_tdata,  // [TIME_BITS-1:0] rto_us
   input  wire logic                          csr_wen,
   input  wire logic [CSR_ADDR_WIDTH-1:0]     csr_addr,
   input  wire logic [TIME_BITS-1:0]          csr_wdata
);

   localparam int DATA_W = ((TIME_BITS + 7) / 8) * 8;

   logic [GAIN_WIDTH-1:0] var_gain;
   logic [TIME_BITS-1:0]  rto_floor, rto_ceiling, sample_floor, init_srtt, init_dev;

   logic                  in_valid_ff, in_valid_in;
   req_kind_type          in_kind_ff;
   logic [TIME_BITS-1:0]  in_sample_ff;
   logic                  out_valid_ff, out_valid_in;
   logic [TIME_BITS-1:0]  out_rto_ff;

   logic                  req_fire;
   logic                  has_result;
   logic                  out_free;
   logic                  retire;
   req_ctrl_type          ctrl;
   logic [TIME_BITS-1:0]  rto;

   assign has_result = (in_kind_ff == REQ_LOOKUP) || (in_kind_ff == REQ_NORMAL);
   assign out_free   = !out_valid_ff || rsp_tready;
   assign retire     = in_valid_ff && (!has_result || out_free);
   assign req_tready = !in_valid_ff || retire;
   assign req_fire   = req_tvalid && req_tready;

   assign ctrl.valid = retire;
   assign ctrl.kind  = in_kind_ff;

   assign in_valid_in  = req_fire || (in_valid_ff && !retire);
   assign out_valid_in = (retire && has_result) || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_kind_ff   <= req_kind_type'(req_tuser);
         in_sample_ff <= req_tdata[TIME_BITS-1:0];
      end
      if (retire && has_result) begin
         out_rto_ff <= rto;
      end
   end

   rtte_csr #(
      .TIME_BITS (TIME_BITS)
   ) u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_wen      (csr_wen),
      .csr_addr     (csr_addr),
      .csr_wdata    (csr_wdata),
      .var_gain     (var_gain),
      .rto_floor    (rto_floor),
      .rto_ceiling  (rto_ceiling),
      .sample_floor (sample_floor),
      .init_srtt    (init_srtt),
      .init_dev     (init_dev)
   );

   rtte_estimator #(
      .TIME_BITS (TIME_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_est (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .sample       (in_sample_ff),
      .var_gain     (var_gain),
      .rto_floor    (rto_floor),
      .rto_ceiling  (rto_ceiling),
      .sample_floor (sample_floor),
      .init_srtt    (init_srtt),
      .init_dev     (init_dev),
      .rto          (rto)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = DATA_W'(out_rto_ff);

endmodule

`default_nettype wire

@@ design/rtte_checker.sv @@
// ----------------------------------------------------------------------------
// RTT estimator port checker
// Watches the top level's ports for handshake and flow-control slips.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rtt_estimator_rto_unit_assert.svh"

module rtte_checker
   import rtte_pkg::*;
#(
   parameter int TIME_BITS = 26
) (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_tready,
   input wire logic                          rsp_tvalid,
   input wire logic                          rsp_tready,
   input wire logic [((TIME_BITS+7)/8)*8-1:0] rsp_tdata
);

   // A result that is not taken stays, unchanged.
   `RTTE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata))

   // With room for a result the block can always take a new item.
   `RTTE_ASSERT_IMPL(a_req_ready, clock, reset, !rsp_tvalid || rsp_tready,
      req_tready)

   // Padding above the RTO field is always zero.
   `RTTE_ASSERT_IMPL(a_rsp_pad, clock, reset, rsp_tvalid,
      (rsp_tdata >> TIME_BITS) == '0)

   // Nothing is offered straight after reset.
   `RTTE_ASSERT_ALWAYS_NEXT(a_reset_empty, clock, reset, !rsp_tvalid)

endmodule

bind rtt_estimator_rto_unit rtte_checker #(
   .TIME_BITS (TIME_BITS)
) u_rtte_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
